@@ design/dams_pkg.sv @@
// ----------------------------------------------------------------------------
// dams_pkg
// Shared types and constants for the decimal accumulator machine step block:
// sequencer states, status and opcode codes, decode reciprocals.
// ----------------------------------------------------------------------------
package dams_pkg;

	localparam int MEM_WORDS_DEF = 1000;
	localparam int WORD_W        = 32;
	localparam int PC_W          = 10;
	localparam int PCX_W         = PC_W + 1;
	localparam int DCW_W         = 17;   // bits of a word that decodes cleanly
	localparam int REM_W         = 14;   // word modulo 10000
	localparam int DIGIT_W       = 4;

	// valid instruction words lie in [10000, 120000)
	localparam logic [WORD_W-1:0] WORD_MIN = 32'd10000;
	localparam logic [WORD_W-1:0] WORD_LIM = 32'd120000;

	// reciprocal multipliers: w / 10000 = (w * 429497) >> 32 for w < 120000,
	// r / 1000 = (r * 8389) >> 23 for r < 10000
	localparam logic [WORD_W-1:0] RECIP_OP = 32'd429497;
	localparam logic [WORD_W-1:0] RECIP_RN = 32'd8389;
	localparam int                OP_SHIFT = 32;
	localparam int                RN_SHIFT = 23;
	localparam logic [DCW_W-1:0]  OP_SCALE = 17'd10000;
	localparam logic [REM_W-1:0]  RN_SCALE = 14'd1000;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	// branch condition digits
	localparam logic [DIGIT_W-1:0] COND_LT     = 4'd0;
	localparam logic [DIGIT_W-1:0] COND_LE     = 4'd1;
	localparam logic [DIGIT_W-1:0] COND_EQ     = 4'd2;
	localparam logic [DIGIT_W-1:0] COND_GT     = 4'd3;
	localparam logic [DIGIT_W-1:0] COND_GE     = 4'd4;
	localparam logic [DIGIT_W-1:0] COND_ALWAYS = 4'd5;

	// highest valid register digit
	localparam logic [DIGIT_W-1:0] REG_MAX = 4'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_DEC_OP,
		S_DEC_RN,
		S_OPRD,
		S_EXEC,
		S_MUL_WB,
		S_DIV,
		S_DIV_WB,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_STOP     = 3'd1,
		ST_BAD_OP   = 3'd2,
		ST_DIV_ZERO = 3'd3,
		ST_BAD_COND = 3'd4,
		ST_BAD_REG  = 3'd5,
		ST_PC_OVF   = 3'd6,
		ST_HALTED   = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MULT  = 4'd3,
		OP_MOVER = 4'd4,
		OP_MOVEM = 4'd5,
		OP_COMP  = 4'd6,
		OP_BC    = 4'd7,
		OP_DIV   = 4'd8,
		OP_READ  = 4'd9,
		OP_PRINT = 4'd10,
		OP_STOP  = 4'd11
	} opcode_t;

endpackage

@@ design/dams_in_if.sv @@
// ----------------------------------------------------------------------------
// dams_in_if
// Input channel: load and step transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dams_in_if import dams_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [PC_W-1:0]          load_address;
	logic signed [WORD_W-1:0] load_value;
	logic signed [WORD_W-1:0] read_value;

	modport source (
		output valid, kind, load_address, load_value, read_value,
		input  ready
	);

	modport sink (
		input  valid, kind, load_address, load_value, read_value,
		output ready
	);

endinterface

@@ design/dams_out_if.sv @@
// ----------------------------------------------------------------------------
// dams_out_if
// Result channel: machine state after each transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dams_out_if import dams_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic [PC_W-1:0]          program_counter;
	logic                     print_valid;
	logic signed [WORD_W-1:0] print_value;
	logic                     halted;
	logic [2:0]               status;

	modport source (
		output valid, program_counter, print_valid, print_value, halted, status,
		input  ready
	);

	modport sink (
		input  valid, program_counter, print_valid, print_value, halted, status,
		output ready
	);

endinterface

@@ design/decimal_accumulator_machine_step.sv @@
// ----------------------------------------------------------------------------
// decimal_accumulator_machine_step
// Decimal-coded four-register machine: load transactions fill the word
// memory, step transactions execute one instruction at the program counter.
// ----------------------------------------------------------------------------
//
// channel   modport        handshake            payload
// item      dams_in_if     valid & ready        kind, load_address, load_value,
//                                               read_value
// result    dams_out_if    valid & ready        program_counter, print_valid,
//                                               print_value, halted, status
//
// load, halted step or pc overflow: straight from acceptance to the done state
// step: fetch, reciprocal-multiply decode of the opcode and of the register
// digit, operand read, execute, output load; MULT adds a product write-back;
// DIV runs the 32-step shift-subtract divider, then a quotient write-back
// arst_n clears registers, pc, compare pair and halt flag; the word memory is
// undefined until loaded and gets no clearing pass
// the result sits in an output register: a new transaction may be accepted
// while it waits, and a finished item waits in its last state for the slot
//
module decimal_accumulator_machine_step import dams_pkg::*; #(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	dams_in_if.sink  item,
	dams_out_if.source result
);

	localparam int                AW      = $clog2(MEM_WORDS);
	localparam logic [PCX_W-1:0]  MEM_LIM = PCX_W'(MEM_WORDS);

	// sequencer
	state_t state_q, state_d;

	// architectural state
	logic [PC_W-1:0]   pc_q;
	logic              halt_q;
	logic [WORD_W-1:0] gr_q [4];
	logic [WORD_W-1:0] cmp_l_q, cmp_r_q;

	// per-item working registers
	logic [WORD_W-1:0]  read_val_q;
	logic [DCW_W-1:0]   word_q;
	opcode_t            op_q;
	logic [REM_W-1:0]   rem_q;
	logic [DIGIT_W-1:0] rn_q;
	logic [PC_W-1:0]    addr_q;
	status_t            status_q;
	logic               prt_v_q;
	logic [WORD_W-1:0]  prt_val_q;

	// word memory
	logic [WORD_W-1:0] mem [MEM_WORDS];
	logic [WORD_W-1:0] mem_rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [WORD_W-1:0] mem_wd;

	// shared multiplier
	logic [WORD_W-1:0]   mul_a, mul_b;
	logic [2*WORD_W-1:0] mul_q;

	// iterative divider
	logic [WORD_W-1:0] div_rem_q, div_quo_q, div_den_q;
	logic              div_neg_q;
	logic [4:0]        div_cnt_q;
	logic [WORD_W:0]   div_trial;

	// output register
	logic              out_v_q;
	logic [PC_W-1:0]   out_pc_q;
	logic              out_pv_q;
	logic [WORD_W-1:0] out_pval_q;
	logic              out_halt_q;
	status_t           out_st_q;

	// decode and execute helpers
	logic               accept, out_load;
	logic               pc_ok, addr_ok, load_ok, bad_word, uses_reg, bad_reg;
	logic [1:0]         rd_idx;
	logic [WORD_W-1:0]  r_val, m_val, r_mag, m_mag;
	logic [DIGIT_W-1:0] op_dec, rn_dec;
	logic [DCW_W-1:0]   op_prod, rem_full;
	logic [REM_W-1:0]   rem_dec, rn_prod, addr_full;
	logic               cond_bad, take;

	assign accept   = item.valid && item.ready;
	assign out_load = (state_q == S_DONE) && (!out_v_q || result.ready);

	assign pc_ok   = {1'b0, pc_q} < MEM_LIM;
	assign addr_ok = {1'b0, addr_q} < MEM_LIM;
	assign load_ok = {1'b0, item.load_address} < MEM_LIM;

	// fetched word is an instruction only in [10000, 120000)
	assign bad_word = mem_rd_q[WORD_W-1] || (mem_rd_q < WORD_MIN) || (mem_rd_q >= WORD_LIM);

	// digit extraction from the registered multiplier product
	assign op_dec    = mul_q[OP_SHIFT +: DIGIT_W];
	assign op_prod   = DCW_W'(op_dec * OP_SCALE);
	assign rem_full  = word_q - op_prod;
	assign rem_dec   = rem_full[REM_W-1:0];
	assign rn_dec    = mul_q[RN_SHIFT +: DIGIT_W];
	assign rn_prod   = REM_W'(rn_dec * RN_SCALE);
	assign addr_full = rem_q - rn_prod;

	// register and operand selection
	assign rd_idx = rn_q[1:0] - 2'd1;
	assign r_val  = gr_q[rd_idx];
	assign m_val  = addr_ok ? mem_rd_q : '0;
	assign r_mag  = r_val[WORD_W-1] ? (WORD_W'(0) - r_val) : r_val;
	assign m_mag  = m_val[WORD_W-1] ? (WORD_W'(0) - m_val) : m_val;

	assign uses_reg = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_MULT) ||
	                  (op_q == OP_MOVER) || (op_q == OP_MOVEM) || (op_q == OP_COMP) ||
	                  (op_q == OP_DIV);
	assign bad_reg  = uses_reg && ((rn_q == '0) || (rn_q > REG_MAX));

	// branch condition on the signed compare pair
	always_comb begin
		take     = 1'b0;
		cond_bad = 1'b0;
		case (rn_q)
			COND_LT:     take = $signed(cmp_l_q) <  $signed(cmp_r_q);
			COND_LE:     take = $signed(cmp_l_q) <= $signed(cmp_r_q);
			COND_EQ:     take = cmp_l_q == cmp_r_q;
			COND_GT:     take = $signed(cmp_l_q) >  $signed(cmp_r_q);
			COND_GE:     take = $signed(cmp_l_q) >= $signed(cmp_r_q);
			COND_ALWAYS: take = 1'b1;
			default:     cond_bad = 1'b1;
		endcase
	end

	// one restoring divide step
	assign div_trial = {div_rem_q, div_quo_q[WORD_W-1]} - {1'b0, div_den_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.kind == KIND_LOAD || halt_q || !pc_ok) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			S_FETCH:  state_d = bad_word ? S_DONE : S_DEC_OP;
			S_DEC_OP: state_d = S_DEC_RN;
			S_DEC_RN: state_d = S_OPRD;
			S_OPRD:   state_d = S_EXEC;
			S_EXEC: begin
				if (bad_reg) begin
					state_d = S_DONE;
				end else if (op_q == OP_MULT) begin
					state_d = S_MUL_WB;
				end else if (op_q == OP_DIV && m_val != '0) begin
					state_d = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_MUL_WB: state_d = S_DONE;
			S_DIV:    state_d = (div_cnt_q == '0) ? S_DIV_WB : S_DIV;
			S_DIV_WB: state_d = S_DONE;
			S_DONE:   state_d = out_load ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: handshake, memory port and multiplier operands
	always_comb begin
		item.ready = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = item.load_address[AW-1:0];
		mem_wd     = item.load_value;
		mem_ra     = pc_q[AW-1:0];
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			S_IDLE: begin
				item.ready = 1'b1;
				mem_we     = item.valid && (item.kind == KIND_LOAD) && load_ok;
			end
			S_FETCH: begin
				mul_a = mem_rd_q;
				mul_b = RECIP_OP;
			end
			S_DEC_OP: begin
				mul_a = WORD_W'(rem_dec);
				mul_b = RECIP_RN;
			end
			S_OPRD: mem_ra = addr_q[AW-1:0];
			S_EXEC: begin
				mul_a  = r_val;
				mul_b  = m_val;
				mem_wa = addr_q[AW-1:0];
				mem_wd = (op_q == OP_READ) ? read_val_q : r_val;
				mem_we = !bad_reg && addr_ok && ((op_q == OP_MOVEM) || (op_q == OP_READ));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// word memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		mem_rd_q <= mem[mem_ra];
	end

	// shared multiplier, product registered
	always_ff @(posedge clk) begin
		mul_q <= {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};
	end

	// architectural state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			halt_q  <= 1'b0;
			gr_q    <= '{default: '0};
			cmp_l_q <= '0;
			cmp_r_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && item.kind == KIND_STEP && !halt_q && !pc_ok) begin
						halt_q <= 1'b1;
					end
				end
				S_FETCH: begin
					pc_q <= pc_q + 1'b1;
					if (bad_word) begin
						halt_q <= 1'b1;
					end
				end
				S_EXEC: begin
					if (!bad_reg) begin
						case (op_q)
							OP_ADD:   gr_q[rd_idx] <= r_val + m_val;
							OP_SUB:   gr_q[rd_idx] <= r_val - m_val;
							OP_MOVER: gr_q[rd_idx] <= m_val;
							OP_COMP: begin
								cmp_l_q <= r_val;
								cmp_r_q <= m_val;
							end
							OP_BC: begin
								if (take) begin
									pc_q <= addr_q;
								end
							end
							OP_STOP:  halt_q <= 1'b1;
							default: begin
							end
						endcase
					end
				end
				S_MUL_WB: gr_q[rd_idx] <= mul_q[WORD_W-1:0];
				S_DIV_WB: gr_q[rd_idx] <= div_neg_q ? (WORD_W'(0) - div_quo_q) : div_quo_q;
				default: begin
				end
			endcase
		end
	end

	// working registers, decode fields and divider
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					read_val_q <= item.read_value;
					prt_v_q    <= 1'b0;
					prt_val_q  <= '0;
					if (item.kind == KIND_LOAD) begin
						status_q <= ST_OK;
					end else if (halt_q) begin
						status_q <= ST_HALTED;
					end else if (!pc_ok) begin
						status_q <= ST_PC_OVF;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			S_FETCH: begin
				word_q <= mem_rd_q[DCW_W-1:0];
				if (bad_word) begin
					status_q <= ST_BAD_OP;
				end
			end
			S_DEC_OP: begin
				op_q  <= opcode_t'(op_dec);
				rem_q <= rem_dec;
			end
			S_DEC_RN: begin
				rn_q   <= rn_dec;
				addr_q <= addr_full[PC_W-1:0];
			end
			S_EXEC: begin
				if (bad_reg) begin
					status_q <= ST_BAD_REG;
				end else begin
					case (op_q)
						OP_BC: begin
							if (cond_bad) begin
								status_q <= ST_BAD_COND;
							end
						end
						OP_DIV: begin
							if (m_val == '0) begin
								status_q <= ST_DIV_ZERO;
							end
							div_rem_q <= '0;
							div_quo_q <= r_mag;
							div_den_q <= m_mag;
							div_neg_q <= r_val[WORD_W-1] ^ m_val[WORD_W-1];
							div_cnt_q <= '1;
						end
						OP_PRINT: begin
							prt_v_q   <= 1'b1;
							prt_val_q <= m_val;
						end
						OP_STOP:  status_q <= ST_STOP;
						default: begin
						end
					endcase
				end
			end
			S_DIV: begin
				div_cnt_q <= div_cnt_q - 1'b1;
				if (!div_trial[WORD_W]) begin
					div_rem_q <= div_trial[WORD_W-1:0];
					div_quo_q <= {div_quo_q[WORD_W-2:0], 1'b1};
				end else begin
					div_rem_q <= {div_rem_q[WORD_W-2:0], div_quo_q[WORD_W-1]};
					div_quo_q <= {div_quo_q[WORD_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pc_q   <= pc_q;
			out_pv_q   <= prt_v_q;
			out_pval_q <= prt_val_q;
			out_halt_q <= halt_q;
			out_st_q   <= status_q;
		end
	end

	assign result.valid           = out_v_q;
	assign result.program_counter = out_pc_q;
	assign result.print_valid     = out_pv_q;
	assign result.print_value     = out_pval_q;
	assign result.halted          = out_halt_q;
	assign result.status          = out_st_q;

	// once halted, the machine stays halted
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	// pc never goes past the memory end
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pc_q} <= MEM_LIM)
		else $error("pc beyond memory end");

	// an accepted transaction leaves the idle state
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted transaction not started");

	// divider finishes after its last step
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q == '0) |=> state_q == S_DIV_WB)
		else $error("divider did not write back");

	// already-halted status only reported with the halt flag set
	a_halted_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && status_q == ST_HALTED) |-> halt_q)
		else $error("halted status without halt flag");

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the decimal accumulator machine step block. Random
// programs of valid instructions are loaded and stepped. Extreme data, bad
// register and condition digits and backpressure are mixed in. An in-bench
// machine model predicts every result. The run ends with one halting event
// and then steps and a load on the halted machine.
// ----------------------------------------------------------------------------
module testbench;
	import dams_pkg::*;

	localparam int MEM_DEPTH     = MEM_WORDS_DEF;
	localparam int GAP_MAX       = 15;
	localparam int HALF_ITEMS    = 360;
	localparam int TOTAL_ITEMS   = 720;
	localparam int HOLD_CYCLES   = 120;
	localparam int BURST_STEPS   = 30;
	localparam int DRAIN_CYCLES  = 64;
	localparam int MAX_REPORTS   = 10;
	localparam int TIMEOUT_UNITS = 1000000;

	// decimal field weights of an instruction word
	localparam int DEC_OP        = 10000;
	localparam int DEC_RN        = 1000;
	localparam int DEC_DIGIT     = 10;
	localparam int FIRST_OP_WORD = int'(WORD_MIN);
	localparam int END_OP_WORD   = int'(WORD_LIM);
	localparam int STOP_WORD     = int'(OP_STOP) * DEC_OP;

	localparam logic signed [WORD_W-1:0] WORD_MAX_S = 32'sh7fffffff;
	localparam logic signed [WORD_W-1:0] WORD_MIN_S = 32'sh80000000;

	// small data pool that most operands point into
	localparam int DATA_BASE = 984;
	localparam int DATA_SPAN = 16;
	localparam int D_MAX     = DATA_BASE;
	localparam int D_ONE     = DATA_BASE + 1;
	localparam int D_ZERO    = DATA_BASE + 2;
	localparam int D_NEG1    = DATA_BASE + 3;
	localparam int D_MIN     = DATA_BASE + 4;
	localparam int D_SCRATCH = DATA_BASE + 5;
	localparam int JUMP_DEST = 100;

	typedef enum int {END_STOP, END_BAD_OP, END_PC_OVF} ending_t;

	typedef struct {
		logic                     kind;
		logic [PC_W-1:0]          load_address;
		logic signed [WORD_W-1:0] load_value;
		logic signed [WORD_W-1:0] read_value;
	} machine_item_t;

	typedef struct {
		logic [PC_W-1:0]          program_counter;
		logic                     print_valid;
		logic signed [WORD_W-1:0] print_value;
		logic                     halted;
		status_t                  status;
	} machine_state_t;

	logic clk = 1'b0;
	logic arst_n;

	dams_in_if  item ();
	dams_out_if result ();

	decimal_accumulator_machine_step dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	// machine image kept by the bench
	logic signed [WORD_W-1:0] mem_image [MEM_DEPTH];
	bit                       mem_loaded [MEM_DEPTH];
	logic signed [WORD_W-1:0] gpr [4];
	logic signed [WORD_W-1:0] cmp_left;
	logic signed [WORD_W-1:0] cmp_right;
	int                       pc_model;
	bit                       halt_model;

	machine_state_t expected_q [$];
	int             mismatches;
	int             sent_count;
	bit             no_gaps;
	int             hold_request;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// signed division toward zero, most negative / -1 wraps
	function automatic logic signed [WORD_W-1:0] div_toward_zero(
			logic signed [WORD_W-1:0] num, logic signed [WORD_W-1:0] den);
		if (den == -1)
			return -num;
		return num / den;
	endfunction

	// apply one accepted transaction to the machine image, queue its result
	function automatic void execute_item(machine_item_t it);
		machine_state_t           res;
		logic signed [WORD_W-1:0] w;
		logic signed [WORD_W-1:0] m;
		int                       op;
		int                       addr;
		int                       ri;
		logic [DIGIT_W-1:0]       digit;
		bit                       take;
		res.print_valid = 1'b0;
		res.print_value = '0;
		res.status      = ST_OK;
		take            = 1'b0;
		if (it.kind == KIND_LOAD) begin
			if (it.load_address < MEM_DEPTH) begin
				mem_image[it.load_address]  = it.load_value;
				mem_loaded[it.load_address] = 1'b1;
			end
		end else if (halt_model) begin
			res.status = ST_HALTED;
		end else if (pc_model >= MEM_DEPTH) begin
			res.status = ST_PC_OVF;
			halt_model = 1'b1;
		end else begin
			w = mem_image[pc_model];
			pc_model++;
			if (w < FIRST_OP_WORD || w >= END_OP_WORD) begin
				res.status = ST_BAD_OP;
				halt_model = 1'b1;
			end else begin
				op    = w / DEC_OP;
				digit = DIGIT_W'((w / DEC_RN) % DEC_DIGIT);
				addr  = w % DEC_RN;
				ri    = (digit - 1) & 3;
				m     = mem_image[addr];
				if ((op <= OP_COMP || op == OP_DIV) && (digit == 0 || digit > REG_MAX)) begin
					res.status = ST_BAD_REG;
				end else begin
					case (op)
						OP_ADD:   gpr[ri] = gpr[ri] + m;
						OP_SUB:   gpr[ri] = gpr[ri] - m;
						OP_MULT:  gpr[ri] = gpr[ri] * m;
						OP_MOVER: gpr[ri] = m;
						OP_MOVEM: mem_image[addr] = gpr[ri];
						OP_COMP: begin
							cmp_left  = gpr[ri];
							cmp_right = m;
						end
						OP_BC: begin
							case (digit)
								COND_LT:     take = cmp_left < cmp_right;
								COND_LE:     take = cmp_left <= cmp_right;
								COND_EQ:     take = cmp_left == cmp_right;
								COND_GT:     take = cmp_left > cmp_right;
								COND_GE:     take = cmp_left >= cmp_right;
								COND_ALWAYS: take = 1'b1;
								default:     res.status = ST_BAD_COND;
							endcase
							if (take)
								pc_model = addr;
						end
						OP_DIV: begin
							if (m == 0)
								res.status = ST_DIV_ZERO;
							else
								gpr[ri] = div_toward_zero(gpr[ri], m);
						end
						OP_READ: begin
							mem_image[addr]  = it.read_value;
							mem_loaded[addr] = 1'b1;
						end
						OP_PRINT: begin
							res.print_valid = 1'b1;
							res.print_value = m;
						end
						default: begin
							res.status = ST_STOP;
							halt_model = 1'b1;
						end
					endcase
				end
			end
		end
		res.program_counter = pc_model[PC_W-1:0];
		res.halted          = halt_model;
		expected_q.push_back(res);
	endfunction

	function automatic logic signed [WORD_W-1:0] make_word(int op, int digit, int addr);
		return op * DEC_OP + digit * DEC_RN + addr;
	endfunction

	// data words with a bias toward the edges of the signed range
	function automatic logic signed [WORD_W-1:0] random_data();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 1;
			2:       return -1;
			3:       return WORD_MIN_S;
			4:       return WORD_MAX_S;
			5:       return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	// a non-halting instruction, sometimes with a bad register or condition digit
	function automatic logic signed [WORD_W-1:0] random_instruction();
		int op;
		int digit;
		int addr;
		op = $urandom_range(int'(OP_ADD), int'(OP_PRINT));
		if (op == OP_BC) begin
			digit = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
			addr  = $urandom_range(0, MEM_DEPTH - 1);
		end else begin
			if ($urandom_range(0, 7) == 0)
				digit = $urandom_range(0, 1) ? 0 : $urandom_range(5, 9);
			else
				digit = $urandom_range(1, 4);
			if ($urandom_range(0, 15) < 12)
				addr = DATA_BASE + $urandom_range(0, DATA_SPAN - 1);
			else
				addr = $urandom_range(0, MEM_DEPTH - 1);
		end
		return make_word(op, digit, addr);
	endfunction

	// word at the program counter is loaded and will not halt the machine
	function automatic bit fetch_safe();
		return mem_loaded[pc_model] && mem_image[pc_model] >= FIRST_OP_WORD &&
			mem_image[pc_model] < STOP_WORD;
	endfunction

	// offer one transaction, return at the edge that accepts it
	task automatic send_item(machine_item_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid        <= 1'b1;
		item.kind         <= it.kind;
		item.load_address <= it.load_address;
		item.load_value   <= it.load_value;
		item.read_value   <= it.read_value;
		do @(posedge clk); while (item.ready !== 1'b1);
		execute_item(it);
		sent_count++;
	endtask

	task automatic send_load(int addr, logic signed [WORD_W-1:0] value);
		machine_item_t it;
		it.kind         = KIND_LOAD;
		it.load_address = addr[PC_W-1:0];
		it.load_value   = value;
		it.read_value   = $urandom;
		send_item(it);
	endtask

	task automatic send_step(logic signed [WORD_W-1:0] read_word);
		machine_item_t it;
		it.kind         = KIND_STEP;
		it.load_address = PC_W'($urandom_range(0, 1023));
		it.load_value   = $urandom;
		it.read_value   = read_word;
		send_item(it);
	endtask

	// optionally place a word at pc, make sure its operand is loaded, then step
	task automatic run_instruction(bit load_word, logic signed [WORD_W-1:0] word,
			logic signed [WORD_W-1:0] read_word);
		logic signed [WORD_W-1:0] w;
		int                       addr;
		if (load_word)
			send_load(pc_model, word);
		w = mem_image[pc_model];
		if (w >= FIRST_OP_WORD && w < END_OP_WORD) begin
			addr = w % DEC_RN;
			if (!mem_loaded[addr])
				send_load(addr, random_data());
		end
		send_step(read_word);
	endtask

	// one step of a random program that never halts
	task automatic run_random_step();
		if (pc_model == MEM_DEPTH - 1)
			run_instruction(1'b1, make_word(OP_BC, COND_ALWAYS,
				$urandom_range(0, MEM_DEPTH - 1)), random_data());
		else if (!fetch_safe() || $urandom_range(0, 1))
			run_instruction(1'b1, random_instruction(), random_data());
		else
			run_instruction(1'b0, '0, random_data());
	endtask

	task automatic test_directed_loads();
		send_load(D_MAX, WORD_MAX_S);
		send_load(D_ONE, 1);
		send_load(D_ZERO, 0);
		send_load(D_NEG1, -1);
		send_load(D_MIN, WORD_MIN_S);
		// addresses past the memory end are dropped
		send_load(1023, WORD_MIN_S);
	endtask

	task automatic test_operations();
		run_instruction(1'b1, make_word(OP_MOVER, 1, D_MIN), $urandom);
		// most negative / -1 wraps to itself
		run_instruction(1'b1, make_word(OP_DIV, 1, D_NEG1), $urandom);
		run_instruction(1'b1, make_word(OP_SUB, 1, D_ONE), $urandom);
		run_instruction(1'b1, make_word(OP_ADD, 1, D_ONE), $urandom);
		run_instruction(1'b1, make_word(OP_MULT, 1, D_NEG1), $urandom);
		run_instruction(1'b1, make_word(OP_DIV, 2, D_ZERO), $urandom);
		run_instruction(1'b1, make_word(OP_MOVEM, 1, D_SCRATCH), $urandom);
		// read and print ignore the register digit
		run_instruction(1'b1, make_word(OP_READ, 7, D_SCRATCH), WORD_MAX_S);
		run_instruction(1'b1, make_word(OP_PRINT, 0, D_SCRATCH), $urandom);
		run_instruction(1'b1, make_word(OP_COMP, 4, D_MAX), $urandom);
		run_instruction(1'b1, make_word(OP_BC, COND_LE, JUMP_DEST), $urandom);
		run_instruction(1'b1, make_word(OP_BC, COND_EQ, JUMP_DEST), $urandom);
		run_instruction(1'b1, make_word(OP_ADD, 0, D_ONE), $urandom);
		run_instruction(1'b1, make_word(OP_SUB, 5, D_ONE), $urandom);
		run_instruction(1'b1, make_word(OP_BC, 9, JUMP_DEST), $urandom);
	endtask

	task automatic test_random_program(int stop_at);
		int pick;
		int addr;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 49) == 0)
				no_gaps = !no_gaps;
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// stray data load, sometimes past the memory end
				if ($urandom_range(0, 7) == 0)
					addr = $urandom_range(MEM_DEPTH, 1023);
				else if ($urandom_range(0, 1))
					addr = DATA_BASE + $urandom_range(0, DATA_SPAN - 1);
				else
					addr = $urandom_range(0, MEM_DEPTH - 1);
				send_load(addr, random_data());
			end else begin
				run_random_step();
			end
		end
		no_gaps = 1'b0;
	endtask

	// long result stall while items keep coming at full rate
	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		no_gaps      = 1'b1;
		repeat (BURST_STEPS) run_random_step();
		no_gaps      = 1'b0;
	endtask

	// only one halting event is reachable per run
	task automatic test_halting();
		ending_t                  ending;
		logic signed [WORD_W-1:0] bad;
		ending = ending_t'($urandom_range(0, 2));
		case (ending)
			END_STOP:
				run_instruction(1'b1, make_word(OP_STOP, $urandom_range(0, 9), D_ONE),
					random_data());
			END_BAD_OP: begin
				case ($urandom_range(0, 4))
					0:       bad = WORD_MIN_S;
					1:       bad = -1;
					2:       bad = FIRST_OP_WORD - 1;
					3:       bad = END_OP_WORD;
					default: bad = WORD_MAX_S;
				endcase
				run_instruction(1'b1, bad, random_data());
			end
			default: begin
				// walk off the end of memory
				if (pc_model != MEM_DEPTH - 1)
					run_instruction(1'b1, make_word(OP_BC, COND_ALWAYS, MEM_DEPTH - 1),
						random_data());
				run_instruction(1'b1, make_word(OP_ADD, 1, D_ONE), random_data());
				send_step(random_data());
			end
		endcase
	endtask

	task automatic test_halted_machine();
		send_step(random_data());
		send_load($urandom_range(0, 1023), random_data());
		send_step(random_data());
	endtask

	function automatic void flag_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, what);
	endfunction

	function automatic void check_field(string name, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (got !== want)
			flag_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
	endfunction

	// result sink: random stalls, plus one long hold when requested
	initial begin : result_sink
		int stall;
		forever begin
			if (hold_request > 0) begin
				stall        = hold_request;
				hold_request = 0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (result.valid !== 1'b1);
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		machine_state_t want;
		if (arst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1) begin
			if (expected_q.size() == 0) begin
				flag_mismatch("result transaction with nothing pending");
			end else begin
				want = expected_q.pop_front();
				check_field("program_counter", want.program_counter, result.program_counter);
				check_field("print_valid", want.print_valid, result.print_valid);
				check_field("print_value", want.print_value, result.print_value);
				check_field("halted", want.halted, result.halted);
				check_field("status", want.status, result.status);
			end
		end
	end

	initial begin
		#(TIMEOUT_UNITS);
		$display("** decimal_accumulator_machine_step: FAILED **");
		$finish;
	end

	initial begin
		item.valid        <= 1'b0;
		item.kind         <= KIND_LOAD;
		item.load_address <= '0;
		item.load_value   <= '0;
		item.read_value   <= '0;
		arst_n            <= 1'b0;
		foreach (gpr[i])
			gpr[i] = '0;
		cmp_left   = '0;
		cmp_right  = '0;
		pc_model   = 0;
		halt_model = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_loads();
		test_operations();
		test_random_program(HALF_ITEMS);
		test_backpressure();
		test_random_program(TOTAL_ITEMS);
		test_halting();
		test_halted_machine();
		item.valid <= 1'b0;

		// drain, then give stray results a chance to show up
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** decimal_accumulator_machine_step: PASSED **");
		else
			$display("** decimal_accumulator_machine_step: FAILED **");
		$finish;
	end

endmodule
